/* src/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and codes of the text terminal cell engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int CELL_W = 24;

  // request function codes
  localparam logic [1:0] FUNC_PUT     = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_MOVE    = 2'd2;
  localparam logic [1:0] FUNC_RESTORE = 2'd3;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // screen-mode edit codes
  localparam logic [7:0] ED_HOME       = 8'h01;
  localparam logic [7:0] ED_LEFT       = 8'h02;
  localparam logic [7:0] ED_DELETE     = 8'h04;
  localparam logic [7:0] ED_EOL        = 8'h05;
  localparam logic [7:0] ED_RIGHT      = 8'h06;
  localparam logic [7:0] ED_INS_ON     = 8'h09;
  localparam logic [7:0] ED_CLR_EOL    = 8'h0B;
  localparam logic [7:0] ED_CLS        = 8'h0C;
  localparam logic [7:0] ED_DOWN       = 8'h0E;
  localparam logic [7:0] ED_INS_OFF    = 8'h0F;
  localparam logic [7:0] ED_UP         = 8'h10;
  localparam logic [7:0] ED_SMOOTH_OFF = 8'h14;
  localparam logic [7:0] ED_SMOOTH_ON  = 8'h15;

  // configuration register indexes
  localparam logic [2:0] CFG_TEXT_MODE   = 3'd0;
  localparam logic [2:0] CFG_AUTO_SCROLL = 3'd1;
  localparam logic [2:0] CFG_TEXT_WRAP   = 3'd2;
  localparam logic [2:0] CFG_SCREEN_MODE = 3'd3;
  localparam logic [2:0] CFG_FG_COLOR    = 3'd4;
  localparam logic [2:0] CFG_BG_COLOR    = 3'd5;

  localparam logic [7:0] RESET_FG = 8'd15;
  localparam logic [7:0] RESET_BG = 8'd0;

  typedef enum logic [4:0] {
    OP_NOP, OP_NEWLINE, OP_LEFT, OP_HOME, OP_DELETE, OP_EOL, OP_RIGHT,
    OP_INS_ON, OP_CLR_EOL, OP_CLS, OP_DOWN, OP_INS_OFF, OP_UP,
    OP_SMOOTH_OFF, OP_SMOOTH_ON, OP_PRINT, OP_ADVANCE, OP_READ, OP_MOVE,
    OP_RESTORE
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic       insert_on;
    logic       smooth_on;
  } res_t;

  typedef struct packed {
    logic       text_mode;
    logic       auto_scroll;
    logic       text_wrap;
    logic       screen_mode;
    logic [7:0] fg_color;
    logic [7:0] bg_color;
  } cfg_t;

  // decoded command, col and row already clamped
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic init_busy;
  } back_sts_t;

endpackage

/* src/tte_front.sv */
// ----------------------------------------------------------------------------
// tte_front
// Accepts items, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module tte_front #(
  parameter int NUM_COLS = 64,
  parameter int NUM_ROWS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tte_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  tte_pkg::in_t       in_data,
  output logic               q_valid,
  output tte_pkg::cmd_t      q_cmd,
  input  tte_pkg::back_sts_t sts
);
  import tte_pkg::*;

  op_t        op;
  logic [7:0] col_c;
  logic [7:0] row_c;
  cmd_t       q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    op = OP_NOP;
    case (in_data.func)
      FUNC_PUT: begin
        if (!cfg.text_mode || in_data.char_code == CH_NUL) begin
          op = OP_NOP;
        end else if (in_data.char_code inside {CH_CR, CH_LF}) begin
          op = OP_NEWLINE;
        end else if (in_data.char_code inside {CH_BS, CH_DEL}) begin
          op = OP_LEFT;
        end else if (in_data.char_code < CH_SPACE) begin
          if (!cfg.screen_mode) begin
            op = OP_ADVANCE;
          end else begin
            case (in_data.char_code)
              ED_HOME:       op = OP_HOME;
              ED_LEFT:       op = OP_LEFT;
              ED_DELETE:     op = OP_DELETE;
              ED_EOL:        op = OP_EOL;
              ED_RIGHT:      op = OP_RIGHT;
              ED_INS_ON:     op = OP_INS_ON;
              ED_CLR_EOL:    op = OP_CLR_EOL;
              ED_CLS:        op = OP_CLS;
              ED_DOWN:       op = OP_DOWN;
              ED_INS_OFF:    op = OP_INS_OFF;
              ED_UP:         op = OP_UP;
              ED_SMOOTH_OFF: op = OP_SMOOTH_OFF;
              ED_SMOOTH_ON:  op = OP_SMOOTH_ON;
              default:       op = OP_NOP;
            endcase
          end
        end else begin
          op = OP_PRINT;
        end
      end
      FUNC_READ: op = cfg.text_mode ? OP_READ : OP_NOP;
      FUNC_MOVE: op = OP_MOVE;
      default:   op = OP_RESTORE;
    endcase
  end

  assign col_c = (in_data.col > 8'(NUM_COLS - 1)) ? 8'(NUM_COLS - 1) : in_data.col;
  assign row_c = (in_data.row > 8'(NUM_ROWS - 1)) ? 8'(NUM_ROWS - 1) : in_data.row;

  assign in_ready = (cnt_r != 2'd2) && !sts.init_busy;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (sts.take) begin
      rp_nxt = ~rp_r;
    end
    if (push && !sts.take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && sts.take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{op: op, ch: in_data.char_code, col: col_c, row: row_c};
    end
  end

endmodule

/* src/tte_back.sv */
// ----------------------------------------------------------------------------
// tte_back
// Executes commands on the cell store and the cursor, one command at a time.
// ----------------------------------------------------------------------------
module tte_back #(
  parameter int NUM_COLS = 64,
  parameter int NUM_ROWS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tte_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  tte_pkg::cmd_t      q_cmd,
  output tte_pkg::back_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output tte_pkg::res_t      out_data
);
  import tte_pkg::*;

  localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int AW = RW + CW;
  localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_FILL   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [RW-1:0] saved_r, saved_nxt;
  logic          pend_r, pend_nxt;
  logic          ins_r, ins_nxt;
  logic          smooth_r, smooth_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic [7:0]    rdch_r, rdch_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] d_r, d_nxt;
  logic          p_r, p_nxt;
  logic          idone_r, idone_nxt;
  logic          dir_r, dir_nxt;
  logic [RW-1:0] srow_r, srow_nxt;
  logic          fill_all_r, fill_all_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] lastnz_r, lastnz_nxt;
  logic [7:0]    ch_r, ch_nxt;

  logic [CELL_W-1:0] mem [2**AW];
  logic [CELL_W-1:0] rd_data_r;
  logic              we, re;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd;
  logic [CELL_W-1:0] blank;

  logic          take, finish, adv, nl, scroll_go;
  logic [CW-1:0] qc;
  logic [RW-1:0] qr;

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] l, input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, l} + {1'b0, t};
    if (s >= (RW + 1)'(NUM_ROWS)) begin
      s = s - (RW + 1)'(NUM_ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign blank = {CH_SPACE, cfg.fg_color, cfg.bg_color};
  assign take  = (state_r == S_IDLE) && q_valid && !out_valid_r;
  assign qc    = CW'(q_cmd.col);
  assign qr    = RW'(q_cmd.row);

  assign sts.take      = take;
  assign sts.init_busy = (state_r == S_INIT);

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    saved_nxt     = saved_r;
    pend_nxt      = pend_r;
    ins_nxt       = ins_r;
    smooth_nxt    = smooth_r;
    top_nxt       = top_r;
    scrolled_nxt  = scrolled_r;
    rdch_nxt      = rdch_r;
    out_valid_nxt = out_valid_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    idone_nxt     = idone_r;
    dir_nxt       = dir_r;
    srow_nxt      = srow_r;
    fill_all_nxt  = fill_all_r;
    found_nxt     = found_r;
    lastnz_nxt    = lastnz_r;
    ch_nxt        = ch_r;
    we            = 1'b0;
    re            = 1'b0;
    wa            = '0;
    ra            = '0;
    wd            = blank;
    finish        = 1'b0;
    adv           = 1'b0;
    nl            = 1'b0;
    scroll_go     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (take) begin
          scrolled_nxt = 1'b0;
          rdch_nxt     = 8'd0;
          p_nxt        = 1'b0;
          idone_nxt    = 1'b0;
          case (q_cmd.op)
            OP_NEWLINE: begin
              nl        = 1'b1;
              saved_nxt = (cur_row_r == LAST_ROW) ? LAST_ROW : cur_row_r + 1'b1;
              pend_nxt  = 1'b1;
              finish    = 1'b1;
            end
            OP_LEFT: begin
              if (cur_col_r != '0) cur_col_nxt = cur_col_r - 1'b1;
              finish = 1'b1;
            end
            OP_HOME: begin
              cur_col_nxt = '0;
              finish      = 1'b1;
            end
            OP_RIGHT: begin
              if (cur_col_r != LAST_COL) cur_col_nxt = cur_col_r + 1'b1;
              finish = 1'b1;
            end
            OP_UP: begin
              if (cur_row_r != '0) cur_row_nxt = cur_row_r - 1'b1;
              finish = 1'b1;
            end
            OP_DOWN: begin
              if (cur_row_r != LAST_ROW) cur_row_nxt = cur_row_r + 1'b1;
              finish = 1'b1;
            end
            OP_INS_ON: begin
              ins_nxt = 1'b1;
              finish  = 1'b1;
            end
            OP_INS_OFF: begin
              ins_nxt = 1'b0;
              finish  = 1'b1;
            end
            OP_SMOOTH_ON: begin
              smooth_nxt = 1'b1;
              finish     = 1'b1;
            end
            OP_SMOOTH_OFF: begin
              smooth_nxt = 1'b0;
              finish     = 1'b1;
            end
            OP_MOVE: begin
              cur_col_nxt = qc;
              cur_row_nxt = qr;
              finish      = 1'b1;
            end
            OP_READ: begin
              re        = 1'b1;
              ra        = {phys(qr, top_r), qc};
              state_nxt = S_READ;
            end
            OP_RESTORE: begin
              if (pend_r) begin
                cur_col_nxt = '0;
                pend_nxt    = 1'b0;
                if (saved_r == cur_row_r) begin
                  if (saved_r == LAST_ROW) begin
                    scroll_go = 1'b1;
                  end else begin
                    cur_row_nxt = saved_r + 1'b1;
                  end
                end else begin
                  cur_row_nxt = saved_r;
                end
              end
              finish = 1'b1;
            end
            OP_PRINT: begin
              ch_nxt = q_cmd.ch;
              if (ins_r && cfg.screen_mode && cur_col_r != LAST_COL) begin
                state_nxt = S_SHIFT;
                dir_nxt   = 1'b1;
                k_nxt     = LAST_COL - 1'b1;
                srow_nxt  = phys(cur_row_r, top_r);
              end else begin
                we     = 1'b1;
                wa     = {phys(cur_row_r, top_r), cur_col_r};
                wd     = {q_cmd.ch, cfg.fg_color, cfg.bg_color};
                adv    = 1'b1;
                finish = 1'b1;
              end
            end
            OP_ADVANCE: begin
              adv    = 1'b1;
              finish = 1'b1;
            end
            OP_DELETE: begin
              if (cur_col_r == LAST_COL) begin
                we     = 1'b1;
                wa     = {phys(cur_row_r, top_r), LAST_COL};
                finish = 1'b1;
              end else begin
                state_nxt = S_SHIFT;
                dir_nxt   = 1'b0;
                k_nxt     = cur_col_r + 1'b1;
                srow_nxt  = phys(cur_row_r, top_r);
              end
            end
            OP_EOL: begin
              state_nxt = S_SEARCH;
              k_nxt     = '0;
              found_nxt = 1'b0;
              srow_nxt  = phys(cur_row_r, top_r);
            end
            OP_CLR_EOL: begin
              state_nxt    = S_FILL;
              k_nxt        = cur_col_r;
              fill_all_nxt = 1'b0;
              srow_nxt     = phys(cur_row_r, top_r);
            end
            OP_CLS: begin
              state_nxt    = S_FILL;
              k_nxt        = '0;
              fill_all_nxt = 1'b1;
              srow_nxt     = '0;
              top_nxt      = '0;
              cur_col_nxt  = '0;
              cur_row_nxt  = '0;
            end
            default: finish = 1'b1;
          endcase
        end
      end

      S_READ: begin
        rdch_nxt = rd_data_r[CELL_W-1 -: 8];
        finish   = 1'b1;
      end

      S_SHIFT: begin
        if (p_r) begin
          we = 1'b1;
          wa = {srow_r, d_r};
          wd = rd_data_r;
        end
        if (!idone_r) begin
          re    = 1'b1;
          ra    = {srow_r, k_r};
          p_nxt = 1'b1;
          d_nxt = dir_r ? k_r + 1'b1 : k_r - 1'b1;
          if (k_r == (dir_r ? cur_col_r : LAST_COL)) begin
            idone_nxt = 1'b1;
          end else begin
            k_nxt = dir_r ? k_r - 1'b1 : k_r + 1'b1;
          end
        end else begin
          p_nxt = 1'b0;
        end
        if (idone_r && !p_r) begin
          we = 1'b1;
          if (dir_r) begin
            wa  = {srow_r, cur_col_r};
            wd  = {ch_r, cfg.fg_color, cfg.bg_color};
            adv = 1'b1;
          end else begin
            wa = {srow_r, LAST_COL};
          end
          finish = 1'b1;
        end
      end

      S_SEARCH: begin
        if (p_r && rd_data_r[CELL_W-1 -: 8] != CH_SPACE) begin
          found_nxt  = 1'b1;
          lastnz_nxt = d_r;
        end
        if (!idone_r) begin
          re    = 1'b1;
          ra    = {srow_r, k_r};
          p_nxt = 1'b1;
          d_nxt = k_r;
          if (k_r == LAST_COL) begin
            idone_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          p_nxt = 1'b0;
        end
        if (idone_r && !p_r) begin
          if (!found_r) begin
            cur_col_nxt = '0;
          end else if (lastnz_r == LAST_COL) begin
            cur_col_nxt = LAST_COL;
          end else begin
            cur_col_nxt = lastnz_r + 1'b1;
          end
          finish = 1'b1;
        end
      end

      S_INIT, S_FILL: begin
        we = 1'b1;
        wa = {srow_r, k_r};
        if (state_r == S_INIT) begin
          wd = {CH_SPACE, RESET_FG, RESET_BG};
        end
        if (k_r == LAST_COL) begin
          k_nxt = '0;
          if (fill_all_r && srow_r != LAST_ROW) begin
            srow_nxt = srow_r + 1'b1;
          end else if (state_r == S_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // cursor advance after a printable or skipped byte
    if (adv) begin
      if (cur_col_r == LAST_COL) begin
        if (cfg.text_wrap) nl = 1'b1;
      end else begin
        cur_col_nxt = cur_col_r + 1'b1;
      end
    end

    if (nl) begin
      cur_col_nxt = '0;
      if (cur_row_r == LAST_ROW) begin
        if (cfg.auto_scroll) scroll_go = 1'b1;
      end else begin
        cur_row_nxt = cur_row_r + 1'b1;
      end
    end

    // scroll: rotate the row origin and blank the row that wraps to the bottom
    if (scroll_go) begin
      state_nxt    = S_FILL;
      srow_nxt     = top_r;
      top_nxt      = phys(RW'(1), top_r);
      k_nxt        = '0;
      fill_all_nxt = 1'b0;
      scrolled_nxt = 1'b1;
    end else if (finish) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      saved_r     <= '0;
      pend_r      <= 1'b0;
      ins_r       <= 1'b0;
      smooth_r    <= 1'b1;
      top_r       <= '0;
      scrolled_r  <= 1'b0;
      rdch_r      <= 8'd0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      p_r         <= 1'b0;
      idone_r     <= 1'b0;
      dir_r       <= 1'b0;
      srow_r      <= '0;
      fill_all_r  <= 1'b1;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      saved_r     <= saved_nxt;
      pend_r      <= pend_nxt;
      ins_r       <= ins_nxt;
      smooth_r    <= smooth_nxt;
      top_r       <= top_nxt;
      scrolled_r  <= scrolled_nxt;
      rdch_r      <= rdch_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      p_r         <= p_nxt;
      idone_r     <= idone_nxt;
      dir_r       <= dir_nxt;
      srow_r      <= srow_nxt;
      fill_all_r  <= fill_all_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    lastnz_r <= lastnz_nxt;
    ch_r     <= ch_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.read_char  = rdch_r;
  assign out_data.cursor_col = 6'(cur_col_r);
  assign out_data.cursor_row = 5'(cur_row_r);
  assign out_data.scrolled   = scrolled_r;
  assign out_data.insert_on  = ins_r;
  assign out_data.smooth_on  = smooth_r;

  a_result_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result pending while a command runs");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_col_r <= LAST_COL && cur_row_r <= LAST_ROW && saved_r <= LAST_ROW)
    else $error("cursor out of range");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LAST_ROW && srow_r <= LAST_ROW)
    else $error("row origin out of range");

  a_no_take_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_INIT) && state_r == S_IDLE |-> !out_valid_r)
    else $error("clearing pass produced a result");

  a_one_port_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && idone_r && !p_r |=> !p_r)
    else $error("shift pipeline did not drain");

endmodule

/* src/text_terminal_cell_engine.sv */
// ----------------------------------------------------------------------------
// text_terminal_cell_engine
// Character cell terminal: cell store, cursor, edit commands and scrolling.
// ----------------------------------------------------------------------------
// After reset the block first blanks the whole cell store, one cell a cycle;
// in_ready stays low until it is done. Items then pass a two-entry command
// queue into an executor that owns the cell store, which has one write port
// and one read port, so the store's one write and one read per cycle set the
// rate: cursor moves and mode changes do not touch the store, a plain
// character write or a read touches one cell, an insert or a delete shifts
// the rest of the row, an end-of-line search scans the row, a clear to line
// end blanks the rest of the row, a scroll blanks one row and a clear screen
// blanks every row. Scrolling moves a row origin, so no rows are copied. The
// executor takes a new command only once the previous result has been taken.
module text_terminal_cell_engine #(
  parameter int NUM_COLS = 64,
  parameter int NUM_ROWS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tte_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tte_pkg::res_t  out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_wdata
);
  import tte_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      q_valid;
  cmd_t      q_cmd;
  back_sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_MODE:   cfg_nxt.text_mode   = cfg_wdata[0];
        CFG_AUTO_SCROLL: cfg_nxt.auto_scroll = cfg_wdata[0];
        CFG_TEXT_WRAP:   cfg_nxt.text_wrap   = cfg_wdata[0];
        CFG_SCREEN_MODE: cfg_nxt.screen_mode = cfg_wdata[0];
        CFG_FG_COLOR:    cfg_nxt.fg_color    = cfg_wdata;
        CFG_BG_COLOR:    cfg_nxt.bg_color    = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{text_mode: 1'b1, auto_scroll: 1'b1, text_wrap: 1'b0,
                 screen_mode: 1'b1, fg_color: RESET_FG, bg_color: RESET_BG};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tte_front #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .sts      (sts)
  );

  tte_back #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
